// ===== rtl/slot_alloc_pkg.sv =====
// slot_alloc_pkg: sizes, derived widths, command codes and result status codes of the slot allocator
// used by rtl/slot_allocator_fifo_wait.sv; depends on nothing
`timescale 1ns / 1ps

package slot_alloc_pkg;

  localparam int SLOTS       = 4;
  localparam int QUEUE_DEPTH = 16;
  localparam int ID_WIDTH    = 8;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

  localparam logic       CMD_ARRIVE  = 1'b0;
  localparam logic       CMD_RELEASE = 1'b1;

  localparam logic [2:0] STATUS_GRANTED   = 3'd0;
  localparam logic [2:0] STATUS_QUEUED    = 3'd1;
  localparam logic [2:0] STATUS_FREED     = 3'd2;
  localparam logic [2:0] STATUS_REGRANTED = 3'd3;
  localparam logic [2:0] STATUS_QFULL     = 3'd4;
  localparam logic [2:0] STATUS_BADREL    = 3'd5;

endpackage

// ===== rtl/slot_allocator_fifo_wait.sv =====
// slot_allocator_fifo_wait: slot pool with a fifo wait queue, owner and queue state in memories
// depends on slot_alloc_pkg
`timescale 1ns / 1ps

//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  request | in_valid, in_stall, command, requester_id,       | in
//          | slot_index                                       |
//  result  | out_valid, out_stall, status, grant_id,          | out
//          | grant_slot, departed_id, waiting_count           |
//
// each request passes an accept cycle, which issues the owner and queue-head memory
// reads, and then the execute state, which uses the registered read data and writes back
// one request in flight at a time; in_stall is high during execute and during reset
// execute waits while a previous result is still stalled in the output register
// rst is synchronous; it clears busy bits, queue pointers, count, out_valid, and the fsm
// no clearing pass: memory read data is only used after the entry has been written

module slot_allocator_fifo_wait (
  input  logic       clk,
  input  logic       rst,
  // request channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       command,
  input  logic [7:0] requester_id,
  input  logic [1:0] slot_index,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] status,
  output logic [7:0] grant_id,
  output logic [1:0] grant_slot,
  output logic [7:0] departed_id,
  output logic [4:0] waiting_count
);

  localparam int SLOTS  = slot_alloc_pkg::SLOTS;
  localparam int QDEPTH = slot_alloc_pkg::QUEUE_DEPTH;
  localparam int IDW    = slot_alloc_pkg::ID_WIDTH;
  localparam int SLOT_W = slot_alloc_pkg::SLOT_W;
  localparam int QPTR_W = slot_alloc_pkg::QPTR_W;
  localparam int CNT_W  = slot_alloc_pkg::CNT_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  // state memories
  logic [IDW-1:0] owner_mem [SLOTS];
  logic [IDW-1:0] fifo_mem  [QDEPTH];

  logic [IDW-1:0] owner_rd;
  logic [IDW-1:0] fifo_rd;

  // control state
  logic              state;
  logic [SLOTS-1:0]  busy;
  logic [SLOTS-1:0]  busy_next;
  logic [QPTR_W-1:0] head;
  logic [QPTR_W-1:0] head_next;
  logic [QPTR_W-1:0] tail;
  logic [QPTR_W-1:0] tail_next;
  logic [CNT_W-1:0]  fifo_count;
  logic [CNT_W-1:0]  fifo_count_next;

  // request held for the execute cycle
  logic              cmd_q;
  logic [IDW-1:0]    id_q;
  logic [SLOT_W-1:0] slot_q;
  logic              bad_range_q;

  logic accept;
  logic out_free;
  logic exec_done;

  // lowest free slot
  logic              free_found;
  logic [SLOT_W-1:0] free_slot;

  // write-back and result
  logic              owner_we;
  logic [SLOT_W-1:0] owner_wa;
  logic [IDW-1:0]    owner_wd;
  logic              fifo_we;
  logic [2:0]        res_status;
  logic [IDW-1:0]    res_gid;
  logic [SLOT_W-1:0] res_gslot;
  logic [IDW-1:0]    res_dep;

  assign in_stall  = rst || (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign exec_done = (state == ST_EXEC) && out_free;

  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!busy[i]) begin
        free_found = 1'b1;
        free_slot  = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    busy_next       = busy;
    head_next       = head;
    tail_next       = tail;
    fifo_count_next = fifo_count;
    owner_we        = 1'b0;
    owner_wa        = slot_q;
    owner_wd        = id_q;
    fifo_we         = 1'b0;
    res_status      = slot_alloc_pkg::STATUS_BADREL;
    res_gid         = '0;
    res_gslot       = '0;
    res_dep         = '0;
    if (cmd_q == slot_alloc_pkg::CMD_ARRIVE) begin
      if (free_found && fifo_count == '0) begin
        // nobody waits: take the lowest free slot
        busy_next[free_slot] = 1'b1;
        owner_we   = 1'b1;
        owner_wa   = free_slot;
        owner_wd   = id_q;
        res_status = slot_alloc_pkg::STATUS_GRANTED;
        res_gid    = id_q;
        res_gslot  = free_slot;
      end else if (fifo_count < CNT_W'(QDEPTH)) begin
        fifo_we         = 1'b1;
        tail_next       = (tail == QPTR_W'(QDEPTH - 1)) ? '0 : tail + 1'b1;
        fifo_count_next = fifo_count + 1'b1;
        res_status      = slot_alloc_pkg::STATUS_QUEUED;
      end else begin
        res_status = slot_alloc_pkg::STATUS_QFULL;
      end
    end else if (!bad_range_q && busy[slot_q]) begin
      res_dep = owner_rd;
      if (fifo_count != '0) begin
        // hand the slot straight to the queue head
        head_next       = (head == QPTR_W'(QDEPTH - 1)) ? '0 : head + 1'b1;
        fifo_count_next = fifo_count - 1'b1;
        owner_we   = 1'b1;
        owner_wa   = slot_q;
        owner_wd   = fifo_rd;
        res_status = slot_alloc_pkg::STATUS_REGRANTED;
        res_gid    = fifo_rd;
        res_gslot  = slot_q;
      end else begin
        busy_next[slot_q] = 1'b0;
        res_status        = slot_alloc_pkg::STATUS_FREED;
      end
    end
  end

  // memories: reads issued at accept, writes at execute, never the same cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      owner_rd <= owner_mem[SLOT_W'(slot_index)];
      fifo_rd  <= fifo_mem[head];
    end
    if (exec_done && owner_we) begin
      owner_mem[owner_wa] <= owner_wd;
    end
    if (exec_done && fifo_we) begin
      fifo_mem[tail] <= id_q;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q       <= command;
      id_q        <= requester_id[IDW-1:0];
      slot_q      <= SLOT_W'(slot_index);
      bad_range_q <= (32'(slot_index) >= SLOTS);
    end
    if (exec_done) begin
      status        <= res_status;
      grant_id      <= 8'(res_gid);
      grant_slot    <= 2'(res_gslot);
      departed_id   <= 8'(res_dep);
      waiting_count <= 5'(fifo_count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      busy       <= '0;
      head       <= '0;
      tail       <= '0;
      fifo_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (exec_done) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (exec_done) begin
        busy       <= busy_next;
        head       <= head_next;
        tail       <= tail_next;
        fifo_count <= fifo_count_next;
        out_valid  <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= CNT_W'(QDEPTH))
    else $error("wait count above queue depth");

  a_count_shown: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (waiting_count == 5'(fifo_count)))
    else $error("result waiting count differs from queue count");

  a_regrant_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == slot_alloc_pkg::STATUS_GRANTED ||
                   status == slot_alloc_pkg::STATUS_REGRANTED))
    |-> busy[SLOT_W'(grant_slot)])
    else $error("granted slot not marked busy");

  a_grant_no_wait: assert property (@(posedge clk) disable iff (rst)
    (exec_done && res_status == slot_alloc_pkg::STATUS_GRANTED) |-> (fifo_count == '0))
    else $error("direct grant while requesters wait");
`endif

endmodule

// ===== dv/slot_allocator_fifo_wait_tb.sv =====
// slot_allocator_fifo_wait_tb: self-checking bench for the slot allocator with fifo wait queue
// depends on rtl/slot_alloc_pkg.sv and rtl/slot_allocator_fifo_wait.sv
`timescale 1ns / 1ps

module slot_allocator_fifo_wait_tb;

  localparam int RANDOM_REQUESTS = 800;
  localparam int DRAIN_CYCLES    = 10;
  localparam int TIMEOUT_NS      = 400_000;
  localparam int NUM_DIRECTED    = 25;

  // one result as the block reports it
  typedef struct packed {
    logic [2:0] st;
    logic [7:0] gid;
    logic [1:0] gslot;
    logic [7:0] dep;
    logic [4:0] wcnt;
  } alloc_result_t;

  // one directed row; known = 1 when the result is typed in by hand
  typedef struct {
    logic          cmd;
    logic [7:0]    id;
    logic [1:0]    slot;
    logic          known;
    alloc_result_t res;
  } directed_row_t;

  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY} rx_mode_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic       command;
  logic [7:0] requester_id;
  logic [1:0] slot_index;
  logic       out_valid;
  logic       out_stall;
  logic [2:0] status;
  logic [7:0] grant_id;
  logic [1:0] grant_slot;
  logic [7:0] departed_id;
  logic [4:0] waiting_count;

  slot_allocator_fifo_wait dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .requester_id  (requester_id),
    .slot_index    (slot_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .grant_id      (grant_id),
    .grant_slot    (grant_slot),
    .departed_id   (departed_id),
    .waiting_count (waiting_count)
  );

  // shadow copy of the pool: who holds each slot and who waits in line
  logic [slot_alloc_pkg::ID_WIDTH-1:0] slot_holder [slot_alloc_pkg::SLOTS];
  logic                                slot_taken  [slot_alloc_pkg::SLOTS];
  logic [slot_alloc_pkg::ID_WIDTH-1:0] waiting_ids [$];

  // results still owed by the block, oldest first
  alloc_result_t pending_results [$];
  int            fail_count;

  // sender burst bookkeeping and receiver stall pattern
  int       burst_left;
  rx_mode_t rx_mode;
  int       rx_left;

  // directed part: after-reset error, fill every slot (id zero among them),
  // fill the wait line to the brim, overflow it, then hand slots to waiters
  directed_row_t directed_tbl [NUM_DIRECTED] = '{
    '{slot_alloc_pkg::CMD_RELEASE, 8'h3C, 2'd0, 1'b1,
      '{slot_alloc_pkg::STATUS_BADREL,  8'h00, 2'd0, 8'h00, 5'd0}},
    '{slot_alloc_pkg::CMD_ARRIVE,  8'h01, 2'd2, 1'b1,
      '{slot_alloc_pkg::STATUS_GRANTED, 8'h01, 2'd0, 8'h00, 5'd0}},
    '{slot_alloc_pkg::CMD_ARRIVE,  8'hFF, 2'd0, 1'b1,
      '{slot_alloc_pkg::STATUS_GRANTED, 8'hFF, 2'd1, 8'h00, 5'd0}},
    '{slot_alloc_pkg::CMD_ARRIVE,  8'h00, 2'd1, 1'b1,
      '{slot_alloc_pkg::STATUS_GRANTED, 8'h00, 2'd2, 8'h00, 5'd0}},
    '{slot_alloc_pkg::CMD_ARRIVE,  8'h80, 2'd3, 1'b1,
      '{slot_alloc_pkg::STATUS_GRANTED, 8'h80, 2'd3, 8'h00, 5'd0}},
    '{slot_alloc_pkg::CMD_ARRIVE,  8'h7F, 2'd0, 1'b0, '0},
    '{slot_alloc_pkg::CMD_ARRIVE,  8'h55, 2'd3, 1'b0, '0},
    '{slot_alloc_pkg::CMD_ARRIVE,  8'hAA, 2'd0, 1'b0, '0},
    '{slot_alloc_pkg::CMD_ARRIVE,  8'h02, 2'd1, 1'b0, '0},
    '{slot_alloc_pkg::CMD_ARRIVE,  8'h04, 2'd2, 1'b0, '0},
    '{slot_alloc_pkg::CMD_ARRIVE,  8'h08, 2'd3, 1'b0, '0},
    '{slot_alloc_pkg::CMD_ARRIVE,  8'h10, 2'd0, 1'b0, '0},
    '{slot_alloc_pkg::CMD_ARRIVE,  8'h20, 2'd1, 1'b0, '0},
    '{slot_alloc_pkg::CMD_ARRIVE,  8'h40, 2'd2, 1'b0, '0},
    '{slot_alloc_pkg::CMD_ARRIVE,  8'hFE, 2'd3, 1'b0, '0},
    '{slot_alloc_pkg::CMD_ARRIVE,  8'hFD, 2'd0, 1'b0, '0},
    '{slot_alloc_pkg::CMD_ARRIVE,  8'hFB, 2'd1, 1'b0, '0},
    '{slot_alloc_pkg::CMD_ARRIVE,  8'hF7, 2'd2, 1'b0, '0},
    '{slot_alloc_pkg::CMD_ARRIVE,  8'hEF, 2'd3, 1'b0, '0},
    '{slot_alloc_pkg::CMD_ARRIVE,  8'hDF, 2'd0, 1'b0, '0},
    '{slot_alloc_pkg::CMD_ARRIVE,  8'hBF, 2'd1, 1'b0, '0},
    '{slot_alloc_pkg::CMD_ARRIVE,  8'h99, 2'd2, 1'b1,
      '{slot_alloc_pkg::STATUS_QFULL,   8'h00, 2'd0, 8'h00, 5'd16}},
    '{slot_alloc_pkg::CMD_RELEASE, 8'hFF, 2'd3, 1'b0, '0},
    '{slot_alloc_pkg::CMD_RELEASE, 8'h00, 2'd2, 1'b0, '0},
    '{slot_alloc_pkg::CMD_RELEASE, 8'h66, 2'd1, 1'b0, '0}
  };

  // 2 ns clock
  always #1 clk = ~clk;

  // next state of the pool for one request, and the result it must produce
  function automatic alloc_result_t allocate_step(logic cmd, logic [7:0] id, logic [1:0] slot);
    alloc_result_t r;
    int            free_slot;
    r         = '0;
    free_slot = slot_alloc_pkg::SLOTS;
    if (cmd == slot_alloc_pkg::CMD_ARRIVE) begin
      for (int i = slot_alloc_pkg::SLOTS - 1; i >= 0; i--) begin
        if (!slot_taken[i]) free_slot = i;
      end
      // a free slot goes to the newcomer only when nobody is already in line
      if (free_slot < slot_alloc_pkg::SLOTS && waiting_ids.size() == 0) begin
        slot_holder[free_slot] = id[slot_alloc_pkg::ID_WIDTH-1:0];
        slot_taken[free_slot]  = 1'b1;
        r.st    = slot_alloc_pkg::STATUS_GRANTED;
        r.gid   = 8'(id[slot_alloc_pkg::ID_WIDTH-1:0]);
        r.gslot = 2'(free_slot);
      end else if (waiting_ids.size() < slot_alloc_pkg::QUEUE_DEPTH) begin
        waiting_ids.insert(waiting_ids.size(), id[slot_alloc_pkg::ID_WIDTH-1:0]);
        r.st = slot_alloc_pkg::STATUS_QUEUED;
      end else begin
        r.st = slot_alloc_pkg::STATUS_QFULL;
      end
    end else if (int'(slot) >= slot_alloc_pkg::SLOTS || !slot_taken[slot]) begin
      r.st = slot_alloc_pkg::STATUS_BADREL;
    end else begin
      r.dep = 8'(slot_holder[slot]);
      // freed slot passes straight to the head of the line, if any
      if (waiting_ids.size() > 0) begin
        slot_holder[slot] = waiting_ids[0];
        waiting_ids.delete(0);
        r.st    = slot_alloc_pkg::STATUS_REGRANTED;
        r.gid   = 8'(slot_holder[slot]);
        r.gslot = slot;
      end else begin
        slot_holder[slot] = '0;
        slot_taken[slot]  = 1'b0;
        r.st = slot_alloc_pkg::STATUS_FREED;
      end
    end
    r.wcnt = 5'(waiting_ids.size());
    return r;
  endfunction

  // drive one request from a falling edge, hold it until taken, log what it owes
  task automatic send_request(logic cmd, logic [7:0] id, logic [1:0] slot,
                              logic known, alloc_result_t typed);
    alloc_result_t predicted;
    command      = cmd;
    requester_id = id;
    slot_index   = slot;
    in_valid     = 1'b1;
    do @(posedge clk); while (in_stall);
    predicted = allocate_step(cmd, id, slot);
    pending_results.insert(pending_results.size(), known ? typed : predicted);
    @(negedge clk);
    // sender works in bursts; a gap drops valid and scribbles on the payload
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 6)) begin
        in_valid     = 1'b0;
        command      = 1'($urandom);
        requester_id = 8'($urandom);
        slot_index   = 2'($urandom);
        @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  // receiver stall pattern: switches between open, light and heavy stalling
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      rx_left = $urandom_range(20, 120);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:  out_stall = 1'b0;
      RX_LIGHT: out_stall = ($urandom_range(0, 2) == 0);
      default:  out_stall = ($urandom_range(0, 7) != 0);
    endcase
  end

  // result checker: every accepted result against the oldest owed one
  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: status %0d", status);
        fail_count++;
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (status !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, status);
          fail_count++;
        end
        if (grant_id !== want.gid) begin
          $error("grant_id: expected %0d, got %0d", want.gid, grant_id);
          fail_count++;
        end
        if (grant_slot !== want.gslot) begin
          $error("grant_slot: expected %0d, got %0d", want.gslot, grant_slot);
          fail_count++;
        end
        if (departed_id !== want.dep) begin
          $error("departed_id: expected %0d, got %0d", want.dep, departed_id);
          fail_count++;
        end
        if (waiting_count !== want.wcnt) begin
          $error("waiting_count: expected %0d, got %0d", want.wcnt, waiting_count);
          fail_count++;
        end
      end
    end
  end

  // hard stop in case the block hangs
  initial begin
    #(TIMEOUT_NS);
    $display("TB_ERROR");
    $finish;
  end

  // stimulus
  initial begin
    int          arrive_pct;
    int          busy_list [$];
    logic [7:0]  id;
    logic [1:0]  slot;
    clk          = 1'b0;
    rst          = 1'b1;
    in_valid     = 1'b0;
    command      = slot_alloc_pkg::CMD_ARRIVE;
    requester_id = '0;
    slot_index   = '0;
    out_stall    = 1'b0;
    rx_mode      = RX_OPEN;
    rx_left      = 0;
    burst_left   = $urandom_range(1, 24);
    fail_count   = 0;
    arrive_pct   = 50;
    for (int i = 0; i < slot_alloc_pkg::SLOTS; i++) begin
      slot_holder[i] = '0;
      slot_taken[i]  = 1'b0;
    end

    repeat (8) @(negedge clk);
    rst = 1'b0;

    foreach (directed_tbl[i]) begin
      send_request(directed_tbl[i].cmd, directed_tbl[i].id, directed_tbl[i].slot,
                   directed_tbl[i].known, directed_tbl[i].res);
    end

    // random part: the arrival mix swings so the line fills up and drains again
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 2))
          0:       arrive_pct = 15;
          1:       arrive_pct = 50;
          default: arrive_pct = 85;
        endcase
      end
      id   = 8'($urandom);
      slot = 2'($urandom);
      if ($urandom_range(0, 99) < arrive_pct) begin
        // id zero now and then, otherwise any id
        if ($urandom_range(0, 19) == 0) id = 8'h00;
        send_request(slot_alloc_pkg::CMD_ARRIVE, id, slot, 1'b0, '0);
      end else begin
        // mostly release a slot that is really held, sometimes any slot
        busy_list.delete();
        for (int i = 0; i < slot_alloc_pkg::SLOTS; i++) begin
          if (slot_taken[i]) busy_list.insert(busy_list.size(), i);
        end
        if (busy_list.size() > 0 && $urandom_range(0, 9) != 0) begin
          slot = 2'(busy_list[$urandom_range(0, busy_list.size() - 1)]);
        end
        send_request(slot_alloc_pkg::CMD_RELEASE, id, slot, 1'b0, '0);
      end
    end

    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
